[hdl/sprite_rle_palette_decoder_core_defines.svh]
// Assertion macros for the sprite RLE palette decoder.
`ifndef SPRITE_RLE_PALETTE_DECODER_CORE_DEFINES_SVH
`define SPRITE_RLE_PALETTE_DECODER_CORE_DEFINES_SVH

// checked only out of reset
`define SRPD_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SRPD_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/srpd_pkg.sv]
// Shared types and constants for the sprite RLE palette decoder.
package srpd_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COLOR_W           = 6;
  localparam int RGB_W             = 3 * COLOR_W;
  localparam logic [9:0] COL_MAX   = 10'd511;

  typedef enum logic [1:0] {
    FUNC_PALETTE = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_DATA    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] x;
    logic [7:0] y;
    logic       pal_ok;
  } res_t;

endpackage

[hdl/srpd_palette.sv]
// Palette memory: one write port, one registered read port.
module srpd_palette
  import srpd_pkg::*;
#(
  parameter int PaletteDepth = PALETTE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(PaletteDepth)-1:0] wr_addr,
  input  logic [RGB_W-1:0]                wr_data,
  input  logic                            rd_en,
  input  logic [$clog2(PaletteDepth)-1:0] rd_addr,
  output logic [RGB_W-1:0]                rd_data
);

  logic [RGB_W-1:0] mem [PaletteDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/srpd_ctrl.sv]
// Position and run state; decides the result of each accepted word.
module srpd_ctrl
  import srpd_pkg::*;
#(
  parameter int PaletteDepth = PALETTE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  func_t      func,
  input  logic [7:0] data_byte,
  input  logic [7:0] sprite_width,
  input  logic [7:0] sprite_height,
  output res_t       res
);

  logic [7:0] cur_row, cur_row_next;
  logic [8:0] cur_col, cur_col_next;
  logic [6:0] run_left, run_left_next;
  logic       decoding, decoding_next;

  logic [9:0] skip;
  logic [9:0] col_sum;
  logic [7:0] row_inc;

  assign skip    = {2'b00, ~data_byte} + 10'd1;
  assign col_sum = {1'b0, cur_col} + skip;
  assign row_inc = cur_row + 8'd1;

  always_comb begin
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    run_left_next = run_left;
    decoding_next = decoding;
    res.valid     = 1'b0;
    res.kind      = KIND_PIXEL;
    res.x         = '0;
    res.y         = '0;
    res.pal_ok    = 32'(data_byte) < PaletteDepth;
    case (func)
      FUNC_START: begin
        cur_row_next  = '0;
        cur_col_next  = '0;
        run_left_next = '0;
        decoding_next = 1'b1;
        if (sprite_height == 8'd0) begin
          decoding_next = 1'b0;
          res.valid     = 1'b1;
          res.kind      = KIND_DONE;
        end
      end
      FUNC_DATA: begin
        if (decoding) begin
          if (run_left != 7'd0) begin
            run_left_next = run_left - 7'd1;
            if (cur_col < {1'b0, sprite_width}) begin
              res.valid    = 1'b1;
              res.x        = cur_col[7:0];
              res.y        = cur_row;
              cur_col_next = cur_col + 9'd1;
            end
          end else if (data_byte[7]) begin
            cur_col_next = (col_sum > COL_MAX) ? COL_MAX[8:0] : col_sum[8:0];
          end else if (data_byte == 8'd0) begin
            cur_col_next = '0;
            cur_row_next = row_inc;
            if (row_inc >= sprite_height) begin
              decoding_next = 1'b0;
              res.valid     = 1'b1;
              res.kind      = KIND_DONE;
            end
          end else begin
            run_left_next = data_byte[6:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= '0;
      cur_col  <= '0;
      run_left <= '0;
      decoding <= 1'b0;
    end else if (accept) begin
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      run_left <= run_left_next;
      decoding <= decoding_next;
    end
  end

endmodule

[hdl/sprite_rle_palette_decoder_core.sv]
// The result of an accepted input word is registered in the s1 stage, then in the output register.
// Throughput: one input word per cycle unless the output stalls with both stages full;
// the single palette read port is the only shared resource and is used once per word.
// Reset (rst, synchronous): position, run, decoding flag, registers and pipeline
// valids clear; palette contents are left as they were.
module sprite_rle_palette_decoder_core
  import srpd_pkg::*;
#(
  parameter int PaletteDepth = PALETTE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] palette_index, [13:8] palette_red, [19:14] palette_green,
  // [25:20] palette_blue, [33:26] data_byte, [39:34] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] pixel_x, [15:8] pixel_y, [23:16] out_red, [31:24] out_green,
  // [39:32] out_blue
  output logic [39:0] m_axis_tdata,
  // [0] kind
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AddrW = $clog2(PaletteDepth);

  logic [7:0] sprite_width, sprite_height;

  logic       accept;
  logic       s1_adv;
  func_t      func;
  logic [7:0] palette_index;
  logic [7:0] data_byte;
  logic [RGB_W-1:0] wr_rgb;
  logic [RGB_W-1:0] rd_rgb;
  res_t       res;

  logic       s1_valid;
  res_t       s1_res;

  logic       out_valid;
  logic       out_kind;
  logic [39:0] out_data;
  logic [RGB_W-1:0] rgb_sel;

  assign func          = func_t'(s_axis_tuser);
  assign palette_index = s_axis_tdata[7:0];
  assign wr_rgb        = {s_axis_tdata[13:8], s_axis_tdata[19:14], s_axis_tdata[25:20]};
  assign data_byte     = s_axis_tdata[33:26];

  assign s1_adv        = !s1_valid || !out_valid || m_axis_tready;
  assign s_axis_tready = s1_adv;
  assign accept        = s_axis_tvalid && s1_adv;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width  <= '0;
      sprite_height <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  sprite_width  <= cfg_data;
        REG_HEIGHT: sprite_height <= cfg_data;
        default: ;
      endcase
    end
  end

  srpd_ctrl #(.PaletteDepth(PaletteDepth)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .func          (func),
    .data_byte     (data_byte),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .res           (res)
  );

  srpd_palette #(.PaletteDepth(PaletteDepth)) u_palette (
    .clk     (clk),
    .wr_en   (accept && func == FUNC_PALETTE && 32'(palette_index) < PaletteDepth),
    .wr_addr (palette_index[AddrW-1:0]),
    .wr_data (wr_rgb),
    .rd_en   (s1_adv),
    .rd_addr (data_byte[AddrW-1:0]),
    .rd_data (rd_rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= accept && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_res <= res;
    end
  end

  assign rgb_sel = (s1_res.kind == KIND_PIXEL && s1_res.pal_ok) ? rd_rgb : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && (!out_valid || m_axis_tready)) begin
      out_kind <= s1_res.kind;
      out_data <= {rgb_sel[5:0], 2'b00, rgb_sel[11:6], 2'b00, rgb_sel[17:12], 2'b00,
                   s1_res.y, s1_res.x};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;

endmodule

[hdl/srpd_checker.sv]
// Port-level checks for the sprite RLE palette decoder, bound to the top level.
`include "sprite_rle_palette_decoder_core_defines.svh"

module srpd_checker
  import srpd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  `SRPD_CHECK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")
  `SRPD_CHECK(a_done_zero, m_axis_tvalid && m_axis_tuser == KIND_DONE |-> m_axis_tdata == 40'd0, "done word carries nonzero data")
  `SRPD_CHECK(a_ready_follows, m_axis_tready |-> s_axis_tready, "input stalled while output drains")
  `SRPD_CHECK_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind sprite_rle_palette_decoder_core srpd_checker u_srpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/sprite_rle_palette_decoder_core_tb.sv]
// Self-checking testbench for the sprite RLE palette decoder: directed and random streams.
`timescale 1ns / 1ps

module sprite_rle_palette_decoder_core_tb;
  import srpd_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } sprite_word_t;

  typedef struct {
    bit           is_reg;
    logic         reg_sel;
    logic [7:0]   val;
    func_t        f;
    logic [7:0]   idx;
    logic [5:0]   r;
    logic [5:0]   g;
    logic [5:0]   b;
    logic [7:0]   byt;
    bit           typed;
    bit           typed_has;
    sprite_word_t typed_w;
  } dir_step_t;

  localparam sprite_word_t DONE_WORD = {KIND_DONE, 40'd0};
  localparam sprite_word_t NO_WORD   = '0;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  sprite_rle_palette_decoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // decoder shadow state
  logic [17:0]  pal_rgb [256];
  bit           pal_set [256];
  logic [7:0]   inked[$];
  logic [7:0]   row_pos    = '0;
  logic [8:0]   col_pos    = '0;
  logic [6:0]   run_left   = '0;
  bit           busy       = 0;
  logic [7:0]   cur_width  = '0;
  logic [7:0]   cur_height = '0;

  sprite_word_t pending_pixels[$];
  dir_step_t    dir_steps[$];
  int           mismatches = 0;
  int           live_items = 0;
  bit           calm       = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void queue_word(input sprite_word_t w);
    pending_pixels.insert(pending_pixels.size(), w);
  endfunction

  function automatic void add_step(input dir_step_t s);
    dir_steps.insert(dir_steps.size(), s);
  endfunction

  function automatic void decode_word(input func_t f, input logic [7:0] idx,
                                      input logic [5:0] r, input logic [5:0] g,
                                      input logic [5:0] b, input logic [7:0] byt,
                                      output bit has, output sprite_word_t w);
    int          next_col;
    logic [17:0] rgb;
    has = 0;
    w = NO_WORD;
    case (f)
      FUNC_PALETTE: begin
        pal_rgb[idx] = {r, g, b};
        if (!pal_set[idx]) begin
          pal_set[idx] = 1;
          inked.insert(inked.size(), idx);
        end
      end
      FUNC_START: begin
        row_pos = '0;
        col_pos = '0;
        run_left = '0;
        busy = 1;
        if (cur_height == 0) begin
          busy = 0;
          has = 1;
          w = DONE_WORD;
        end
      end
      FUNC_DATA: begin
        if (busy) begin
          if (run_left != 0) begin
            run_left = run_left - 7'd1;
            if (col_pos < {1'b0, cur_width}) begin
              rgb = pal_rgb[byt];
              has = 1;
              w = {KIND_PIXEL, col_pos[7:0], row_pos, rgb[17:12], 2'b00,
                   rgb[11:6], 2'b00, rgb[5:0], 2'b00};
              col_pos = col_pos + 9'd1;
            end
          end else if (byt[7]) begin
            next_col = int'(col_pos) + (256 - int'(byt));
            col_pos = (next_col > 511) ? 9'd511 : next_col[8:0];
          end else if (byt == 0) begin
            col_pos = '0;
            row_pos = row_pos + 8'd1;
            if (row_pos >= cur_height) begin
              busy = 0;
              has = 1;
              w = DONE_WORD;
            end
          end else begin
            run_left = byt[6:0];
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    sprite_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch("word with nothing pending", 0, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tuser !== want.kind) flag_mismatch("kind", want.kind, m_axis_tuser);
        if (m_axis_tdata[7:0] !== want.x) flag_mismatch("pixel_x", want.x, m_axis_tdata[7:0]);
        if (m_axis_tdata[15:8] !== want.y) flag_mismatch("pixel_y", want.y, m_axis_tdata[15:8]);
        if (m_axis_tdata[23:16] !== want.r) flag_mismatch("red", want.r, m_axis_tdata[23:16]);
        if (m_axis_tdata[31:24] !== want.g)
          flag_mismatch("green", want.g, m_axis_tdata[31:24]);
        if (m_axis_tdata[39:32] !== want.b) flag_mismatch("blue", want.b, m_axis_tdata[39:32]);
      end
    end
  end

  initial begin
    int stall;
    m_axis_tready = 0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready = 0;
        stall--;
      end else begin
        m_axis_tready = 1;
        stall = pick_gap();
      end
    end
  end

  task automatic send_word(input func_t f, input logic [7:0] idx, input logic [5:0] r,
                           input logic [5:0] g, input logic [5:0] b, input logic [7:0] byt,
                           output bit has, output sprite_word_t w);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    // pixel bytes only name palette entries that hold a color
    if (f == FUNC_DATA && busy && run_left != 0 && !pal_set[byt])
      byt = inked[$urandom_range(0, inked.size() - 1)];
    s_axis_tuser = f;
    s_axis_tdata = {6'd0, byt, b, g, r, idx};
    s_axis_tvalid = 1;
    do @(posedge clk); while (!s_axis_tready);
    decode_word(f, idx, r, g, b, byt, has, w);
  endtask

  task automatic feed(input func_t f, input logic [7:0] idx, input logic [5:0] r,
                      input logic [5:0] g, input logic [5:0] b, input logic [7:0] byt);
    bit           has;
    sprite_word_t w;
    live_items++;
    send_word(f, idx, r, g, b, byt, has, w);
    if (has) queue_word(w);
  endtask

  task automatic feed_byte(input logic [7:0] byt);
    feed(FUNC_DATA, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
         6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), byt);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = sel;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    if (sel == REG_WIDTH) cur_width = v;
    else cur_height = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic dir_step_t stim(input func_t f, input logic [7:0] idx,
                                     input logic [5:0] r, input logic [5:0] g,
                                     input logic [5:0] b, input logic [7:0] byt);
    dir_step_t s;
    s.is_reg = 0;
    s.reg_sel = REG_WIDTH;
    s.val = '0;
    s.f = f;
    s.idx = idx;
    s.r = r;
    s.g = g;
    s.b = b;
    s.byt = byt;
    s.typed = 0;
    s.typed_has = 0;
    s.typed_w = NO_WORD;
    return s;
  endfunction

  function automatic dir_step_t pinned(input dir_step_t s, input bit has,
                                       input sprite_word_t w);
    s.typed = 1;
    s.typed_has = has;
    s.typed_w = w;
    return s;
  endfunction

  function automatic dir_step_t reg_step(input logic sel, input logic [7:0] v);
    dir_step_t s;
    s = stim(FUNC_NONE, 0, 0, 0, 0, 0);
    s.is_reg = 1;
    s.reg_sel = sel;
    s.val = v;
    return s;
  endfunction

  initial begin
    bit           has;
    sprite_word_t w;
    int           rows;
    int           segs;
    int           n;
    int           roll;
    logic [7:0]   h;

    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = FUNC_PALETTE;
    cfg_valid = 0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    foreach (pal_set[i]) pal_set[i] = 0;

    add_step(pinned(stim(FUNC_DATA, 0, 0, 0, 0, 8'h05), 0, NO_WORD));
    add_step(pinned(stim(FUNC_NONE, 8'hFF, 63, 63, 63, 8'hFF), 0, NO_WORD));
    add_step(pinned(stim(FUNC_START, 0, 0, 0, 0, 0), 1, DONE_WORD));
    add_step(stim(FUNC_PALETTE, 8'd0, 63, 63, 63, 8'hFF));
    add_step(stim(FUNC_PALETTE, 8'd255, 0, 0, 0, 8'h00));
    add_step(stim(FUNC_PALETTE, 8'd1, 1, 2, 3, 8'h00));
    add_step(reg_step(REG_WIDTH, 8'd255));
    add_step(reg_step(REG_HEIGHT, 8'd255));
    add_step(stim(FUNC_START, 0, 0, 0, 0, 0));
    add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'h03));
    add_step(pinned(stim(FUNC_DATA, 0, 0, 0, 0, 8'h00), 1,
                    {KIND_PIXEL, 8'd0, 8'd0, 8'd252, 8'd252, 8'd252}));
    add_step(pinned(stim(FUNC_DATA, 0, 0, 0, 0, 8'hFF), 1,
                    {KIND_PIXEL, 8'd1, 8'd0, 24'd0}));
    add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'h01));
    // four maximal skips run the column into saturation
    repeat (4) add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'h80));
    add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'h7F));
    add_step(pinned(stim(FUNC_DATA, 0, 0, 0, 0, 8'h00), 0, NO_WORD));
    add_step(stim(FUNC_START, 0, 0, 0, 0, 0));
    add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'h00));
    add_step(reg_step(REG_HEIGHT, 8'd1));
    add_step(pinned(stim(FUNC_DATA, 0, 0, 0, 0, 8'h00), 1, DONE_WORD));
    add_step(pinned(stim(FUNC_DATA, 0, 0, 0, 0, 8'h01), 0, NO_WORD));
    add_step(reg_step(REG_WIDTH, 8'd2));
    add_step(reg_step(REG_HEIGHT, 8'd2));
    add_step(stim(FUNC_START, 0, 0, 0, 0, 0));
    add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'h03));
    add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'h01));
    add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'h00));
    add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'hFF));
    add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'h00));
    add_step(stim(FUNC_DATA, 0, 0, 0, 0, 8'h00));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_reg) begin
        write_reg(dir_steps[i].reg_sel, dir_steps[i].val);
      end else begin
        send_word(dir_steps[i].f, dir_steps[i].idx, dir_steps[i].r, dir_steps[i].g,
                  dir_steps[i].b, dir_steps[i].byt, has, w);
        if (dir_steps[i].typed) begin
          has = dir_steps[i].typed_has;
          w = dir_steps[i].typed_w;
        end
        if (has) queue_word(w);
      end
    end

    live_items = 0;
    while (live_items < 1100) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) write_reg(REG_WIDTH, 8'd0);
        else if (roll < 20) write_reg(REG_WIDTH, 8'd255);
        else if (roll < 80) write_reg(REG_WIDTH, 8'($urandom_range(1, 16)));
        else write_reg(REG_WIDTH, 8'($urandom_range(17, 64)));
      end
      if ($urandom_range(0, 9) < 7) begin
        roll = $urandom_range(0, 99);
        if (roll < 15) h = 8'd0;
        else if (roll < 25) h = 8'd255;
        else if (roll < 85) h = 8'($urandom_range(1, 4));
        else h = 8'($urandom_range(5, 12));
        write_reg(REG_HEIGHT, h);
      end
      repeat ($urandom_range(0, 8))
        feed(FUNC_PALETTE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
             6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
             8'($urandom_range(0, 255)));
      // mostly fresh sprites; some phases carry on the one in progress
      if ($urandom_range(0, 4) != 0)
        feed(FUNC_START, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
             6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
             8'($urandom_range(0, 255)));
      rows = (cur_height > 6) ? $urandom_range(1, 6) : cur_height + $urandom_range(0, 1);
      repeat (rows) begin
        segs = $urandom_range(0, 3);
        repeat (segs) begin
          roll = $urandom_range(0, 99);
          if (roll < 5) begin
            feed(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
          end else if (roll < 30) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            feed_byte(8'(256 - n));
          end else begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 127) : $urandom_range(1, 6);
            feed_byte(n[7:0]);
            repeat (n) feed_byte(8'($urandom_range(0, 255)));
          end
        end
        feed_byte(8'h00);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
